/* design/srm_pkg.sv */
`default_nettype none

package srm_pkg;

  localparam int NUM_REGS   = 6;
  localparam int DATA_WIDTH = 32;
  localparam int IDX_W      = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;

  // fixed field widths
  localparam int OPND_W     = 32;
  localparam int FUNC_W     = 4;
  localparam int DEST_W     = 3;
  localparam int OUT_W      = 32;
  localparam int IPREG_W    = 3;
  localparam int PLEN_W     = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;
  localparam int PLEN_RESET = 1024;

  // queue between front and back
  localparam int CMD_DEPTH  = 2;
  localparam int CMD_PTR_W  = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
  localparam int CMD_CNT_W  = $clog2(CMD_DEPTH + 1);

  // result queue
  localparam int OUT_DEPTH  = 4;
  localparam int OUT_PTR_W  = (OUT_DEPTH > 1) ? $clog2(OUT_DEPTH) : 1;
  localparam int OUT_CNT_W  = $clog2(OUT_DEPTH + 1);
  localparam int OUT_SUM_W  = OUT_CNT_W + 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IP_REGISTER    = 2'd0,
    CFG_PROGRAM_LENGTH = 2'd1
  } cfg_reg_t;

  typedef enum logic [FUNC_W-1:0] {
    OP_BANI = 4'd0,
    OP_BANR = 4'd1,
    OP_MULI = 4'd2,
    OP_SETR = 4'd3,
    OP_BORI = 4'd4,
    OP_EQRR = 4'd5,
    OP_GTIR = 4'd6,
    OP_MULR = 4'd7,
    OP_GTRR = 4'd8,
    OP_SETI = 4'd9,
    OP_GTRI = 4'd10,
    OP_EQRI = 4'd11,
    OP_ADDI = 4'd12,
    OP_BORR = 4'd13,
    OP_EQIR = 4'd14,
    OP_ADDR = 4'd15
  } opcode_t;

  typedef enum logic [2:0] {
    K_ADD,
    K_MUL,
    K_AND,
    K_OR,
    K_SET,
    K_GT,
    K_EQ
  } kind_t;

  typedef struct packed {
    kind_t kind;
    logic  a_reg;
    logic  b_reg;
    logic  b_used;
  } op_info_t;

  typedef struct packed {
    kind_t                 kind;
    logic                  a_reg;
    logic                  b_reg;
    logic [DATA_WIDTH-1:0] a_imm;
    logic [DATA_WIDTH-1:0] b_imm;
    logic [IDX_W-1:0]      a_idx;
    logic [IDX_W-1:0]      b_idx;
    logic [IDX_W-1:0]      dest;
    logic                  bad;
  } cmd_t;

  typedef struct packed {
    logic [DATA_WIDTH-1:0] ip;
    logic [DATA_WIDTH-1:0] written;
    logic [DATA_WIDTH-1:0] reg0;
    logic                  bad;
  } res_t;

  typedef struct packed {
    logic [IPREG_W-1:0] ip_register;
    logic [PLEN_W-1:0]  program_length;
  } cfg_t;

  function automatic op_info_t op_decode(input opcode_t op);
    op_info_t info;
    case (op)
      OP_BANI: info = '{kind: K_AND, a_reg: 1'b1, b_reg: 1'b0, b_used: 1'b1};
      OP_BANR: info = '{kind: K_AND, a_reg: 1'b1, b_reg: 1'b1, b_used: 1'b1};
      OP_MULI: info = '{kind: K_MUL, a_reg: 1'b1, b_reg: 1'b0, b_used: 1'b1};
      OP_SETR: info = '{kind: K_SET, a_reg: 1'b1, b_reg: 1'b0, b_used: 1'b0};
      OP_BORI: info = '{kind: K_OR,  a_reg: 1'b1, b_reg: 1'b0, b_used: 1'b1};
      OP_EQRR: info = '{kind: K_EQ,  a_reg: 1'b1, b_reg: 1'b1, b_used: 1'b1};
      OP_GTIR: info = '{kind: K_GT,  a_reg: 1'b0, b_reg: 1'b1, b_used: 1'b1};
      OP_MULR: info = '{kind: K_MUL, a_reg: 1'b1, b_reg: 1'b1, b_used: 1'b1};
      OP_GTRR: info = '{kind: K_GT,  a_reg: 1'b1, b_reg: 1'b1, b_used: 1'b1};
      OP_SETI: info = '{kind: K_SET, a_reg: 1'b0, b_reg: 1'b0, b_used: 1'b0};
      OP_GTRI: info = '{kind: K_GT,  a_reg: 1'b1, b_reg: 1'b0, b_used: 1'b1};
      OP_EQRI: info = '{kind: K_EQ,  a_reg: 1'b1, b_reg: 1'b0, b_used: 1'b1};
      OP_ADDI: info = '{kind: K_ADD, a_reg: 1'b1, b_reg: 1'b0, b_used: 1'b1};
      OP_BORR: info = '{kind: K_OR,  a_reg: 1'b1, b_reg: 1'b1, b_used: 1'b1};
      OP_EQIR: info = '{kind: K_EQ,  a_reg: 1'b0, b_reg: 1'b1, b_used: 1'b1};
      OP_ADDR: info = '{kind: K_ADD, a_reg: 1'b1, b_reg: 1'b1, b_used: 1'b1};
      default: info = '{kind: K_SET, a_reg: 1'b0, b_reg: 1'b0, b_used: 1'b0};
    endcase
    return info;
  endfunction

endpackage

`default_nettype wire

/* design/srm_ram.sv */
`default_nettype none

module srm_ram #(
  parameter  int WIDTH = 32,
  parameter  int DEPTH = 8,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr_a,
  input  logic [AW-1:0]    raddr_b,
  output logic [WIDTH-1:0] rdata_a,
  output logic [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

`default_nettype wire

/* design/srm_front.sv */
`default_nettype none

module srm_front
  import srm_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     push,
  output logic                     full,
  input  logic [FUNC_W-1:0]        func,
  input  logic signed [OPND_W-1:0] operand_a,
  input  logic signed [OPND_W-1:0] operand_b,
  input  logic [DEST_W-1:0]        dest_index,
  output logic                     cmd_valid,
  output cmd_t                     cmd,
  input  logic                     cmd_ready
);

  op_info_t             info;
  cmd_t                 cmd_in;
  cmd_t                 q [CMD_DEPTH];
  logic [CMD_PTR_W-1:0] wr_ptr;
  logic [CMD_PTR_W-1:0] rd_ptr;
  logic [CMD_CNT_W-1:0] count;
  logic                 do_push;
  logic                 do_pop;

  // classify the item: operand kinds and index range checks
  always_comb begin
    info          = op_decode(opcode_t'(func));
    cmd_in.kind   = info.kind;
    cmd_in.a_reg  = info.a_reg;
    cmd_in.b_reg  = info.b_reg && info.b_used;
    cmd_in.a_imm  = DATA_WIDTH'(operand_a);
    cmd_in.b_imm  = info.b_used ? DATA_WIDTH'(operand_b) : '0;
    cmd_in.a_idx  = operand_a[IDX_W-1:0];
    cmd_in.b_idx  = operand_b[IDX_W-1:0];
    cmd_in.dest   = IDX_W'(dest_index);
    cmd_in.bad    = (info.a_reg && ($unsigned(operand_a) >= OPND_W'(NUM_REGS)))
                 || (info.b_used && info.b_reg
                     && ($unsigned(operand_b) >= OPND_W'(NUM_REGS)))
                 || (OPND_W'(dest_index) >= OPND_W'(NUM_REGS));
  end

  assign full      = (count == CMD_CNT_W'(CMD_DEPTH));
  assign cmd_valid = (count != '0);
  assign cmd       = q[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = cmd_valid && cmd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q[wr_ptr] <= cmd_in;
    end
  end

endmodule

`default_nettype wire

/* design/srm_back.sv */
`default_nettype none

module srm_back
  import srm_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic cmd_valid,
  input  cmd_t cmd,
  output logic cmd_ready,
  input  cfg_t cfg,
  input  logic bind_wr,
  output logic res_valid,
  output res_t res_head,
  output logic halted,
  input  logic res_pop
);

  logic                  bound;
  logic [IDX_W-1:0]      ip_idx;
  logic                  x_valid;
  cmd_t                  x_cmd;
  logic                  fwd_valid;
  logic [IDX_W-1:0]      fwd_addr;
  logic [DATA_WIDTH-1:0] fwd_data;
  logic [NUM_REGS-1:0]   reg_valid;
  logic [DATA_WIDTH-1:0] instr_pointer;
  logic [DATA_WIDTH-1:0] reg0;
  logic                  dirty;
  logic [DATA_WIDTH-1:0] rdata_a;
  logic [DATA_WIDTH-1:0] rdata_b;
  logic [DATA_WIDTH-1:0] op_a;
  logic [DATA_WIDTH-1:0] op_b;
  logic [DATA_WIDTH-1:0] result;
  logic                  write_en;
  logic                  writeback;
  logic                  ram_we;
  logic [IDX_W-1:0]      ram_waddr;
  logic [DATA_WIDTH-1:0] ram_wdata;
  logic [DATA_WIDTH-1:0] pre_ip;
  logic [DATA_WIDTH-1:0] ip_next;
  logic [DATA_WIDTH-1:0] reg0_out;
  res_t                  res_in;
  res_t                  res_q [OUT_DEPTH];
  logic [OUT_PTR_W-1:0]  owr_ptr;
  logic [OUT_PTR_W-1:0]  ord_ptr;
  logic [OUT_CNT_W-1:0]  out_count;
  logic                  issue;
  logic                  out_pop;

  assign bound  = (OPND_W'(cfg.ip_register) < OPND_W'(NUM_REGS));
  assign ip_idx = IDX_W'(cfg.ip_register);

  // one execute slot; issue only when its result is sure to find room
  assign cmd_ready = ((OUT_SUM_W'(out_count) + OUT_SUM_W'(x_valid))
                      < OUT_SUM_W'(OUT_DEPTH));
  assign issue     = cmd_valid && cmd_ready;

  srm_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (NUM_REGS)
  ) u_regs (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .raddr_a (cmd.a_idx),
    .raddr_b (cmd.b_idx),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  // bound register reads the pointer; last write is forwarded past the ram
  function automatic logic [DATA_WIDTH-1:0] operand(
    input logic                  is_reg,
    input logic [IDX_W-1:0]      idx,
    input logic [DATA_WIDTH-1:0] imm,
    input logic [DATA_WIDTH-1:0] rdata
  );
    logic [DATA_WIDTH-1:0] v;
    if (!is_reg) begin
      v = imm;
    end else if (bound && (idx == ip_idx)) begin
      v = instr_pointer;
    end else if (fwd_valid && (fwd_addr == idx)) begin
      v = fwd_data;
    end else if (reg_valid[idx]) begin
      v = rdata;
    end else begin
      v = '0;
    end
    return v;
  endfunction

  always_comb begin
    op_a = operand(x_cmd.a_reg, x_cmd.a_idx, x_cmd.a_imm, rdata_a);
    op_b = operand(x_cmd.b_reg, x_cmd.b_idx, x_cmd.b_imm, rdata_b);
    case (x_cmd.kind)
      K_ADD:   result = op_a + op_b;
      K_MUL:   result = op_a * op_b;
      K_AND:   result = op_a & op_b;
      K_OR:    result = op_a | op_b;
      K_SET:   result = op_a;
      K_GT:    result = {{(DATA_WIDTH - 1){1'b0}}, ($signed(op_a) > $signed(op_b))};
      K_EQ:    result = {{(DATA_WIDTH - 1){1'b0}}, (op_a == op_b)};
      default: result = '0;
    endcase
  end

  always_comb begin
    write_en  = x_valid && !x_cmd.bad;
    // bound register lives in instr_pointer; park it in the ram on rebinding
    writeback = bind_wr && dirty && bound;
    ram_we    = write_en || writeback;
    ram_waddr = write_en ? x_cmd.dest : ip_idx;
    ram_wdata = write_en ? result : (instr_pointer - 1'b1);
    pre_ip    = (bound && write_en && (x_cmd.dest == ip_idx)) ? result : instr_pointer;
    ip_next   = pre_ip + 1'b1;
    if (bound && (ip_idx == '0)) begin
      reg0_out = pre_ip;
    end else if (write_en && (x_cmd.dest == '0)) begin
      reg0_out = result;
    end else begin
      reg0_out = reg0;
    end
    res_in.ip      = ip_next;
    res_in.written = write_en ? result : '0;
    res_in.reg0    = reg0_out;
    res_in.bad     = x_cmd.bad;
  end

  assign out_pop   = res_pop && (out_count != '0);
  assign res_valid = (out_count != '0);
  assign res_head  = res_q[ord_ptr];
  assign halted    = res_head.ip[DATA_WIDTH-1]
                  || ({{PLEN_W{1'b0}}, res_head.ip}
                      >= {{DATA_WIDTH{1'b0}}, cfg.program_length});

  always_ff @(posedge clk) begin
    if (rst) begin
      x_valid       <= 1'b0;
      fwd_valid     <= 1'b0;
      reg_valid     <= '0;
      instr_pointer <= '0;
      reg0          <= '0;
      dirty         <= 1'b0;
      owr_ptr       <= '0;
      ord_ptr       <= '0;
      out_count     <= '0;
    end else begin
      x_valid   <= issue;
      fwd_valid <= ram_we;
      if (x_valid) begin
        instr_pointer <= ip_next;
      end
      if (bind_wr) begin
        dirty <= 1'b0;
      end else if (x_valid && bound) begin
        dirty <= 1'b1;
      end
      if (ram_we) begin
        reg_valid[ram_waddr] <= 1'b1;
        if (ram_waddr == '0) begin
          reg0 <= ram_wdata;
        end
      end
      if (x_valid) begin
        owr_ptr <= (owr_ptr == OUT_PTR_W'(OUT_DEPTH - 1)) ? '0 : owr_ptr + 1'b1;
      end
      if (out_pop) begin
        ord_ptr <= (ord_ptr == OUT_PTR_W'(OUT_DEPTH - 1)) ? '0 : ord_ptr + 1'b1;
      end
      case ({x_valid, out_pop})
        2'b10:   out_count <= out_count + 1'b1;
        2'b01:   out_count <= out_count - 1'b1;
        default: out_count <= out_count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    fwd_addr <= ram_waddr;
    fwd_data <= ram_wdata;
    if (issue) begin
      x_cmd <= cmd;
    end
    if (x_valid) begin
      res_q[owr_ptr] <= res_in;
    end
  end

endmodule

`default_nettype wire

/* design/six_register_machine_step_core.sv */
`default_nettype none

// channel   direction  handshake             payload
// ------------------------------------------------------------------------
// item in   in         push / full           func, operand_a, operand_b,
//                                            dest_index
// result    out        empty / pop           next_ip, halted, written_value,
//                                            reg_zero_value, bad_index
// config    in         cfg_we (no wait)      cfg_index, cfg_data
//
// one item per cycle sustained unless pops stall; a result passes the command
// queue, the execute slot and the result queue before it is visible. The rate
// is set by the single execute stage: operand read, multiply and the pointer
// increment close a loop from item to item. rst is synchronous: registers all
// zero, pointer zero, ip_register 0, program_length 1024. full rises only when
// both queue slots hold items the back end cannot take, i.e. once the
// four-entry result queue, with the execute slot, fills behind a stalled pop

module six_register_machine_step_core
  import srm_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      push,
  output logic                      full,
  input  logic [FUNC_W-1:0]         func,
  input  logic signed [OPND_W-1:0]  operand_a,
  input  logic signed [OPND_W-1:0]  operand_b,
  input  logic [DEST_W-1:0]         dest_index,
  output logic                      empty,
  input  logic                      pop,
  output logic signed [OUT_W-1:0]   next_ip,
  output logic                      halted,
  output logic signed [OUT_W-1:0]   written_value,
  output logic signed [OUT_W-1:0]   reg_zero_value,
  output logic                      bad_index,
  input  logic                      cfg_we,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_DATA_W-1:0]     cfg_data
);

  cfg_t cfg;
  logic bind_wr;
  logic cmd_valid;
  cmd_t cmd;
  logic cmd_ready;
  logic res_valid;
  res_t res_head;

  assign bind_wr = cfg_we && (cfg_index == CFG_IP_REGISTER);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ip_register    <= '0;
      cfg.program_length <= PLEN_W'(PLEN_RESET);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_IP_REGISTER:    cfg.ip_register    <= cfg_data[IPREG_W-1:0];
        CFG_PROGRAM_LENGTH: cfg.program_length <= cfg_data[PLEN_W-1:0];
        default:            cfg                <= cfg;
      endcase
    end
  end

  srm_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .func       (func),
    .operand_a  (operand_a),
    .operand_b  (operand_b),
    .dest_index (dest_index),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd),
    .cmd_ready  (cmd_ready)
  );

  srm_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_ready (cmd_ready),
    .cfg       (cfg),
    .bind_wr   (bind_wr),
    .res_valid (res_valid),
    .res_head  (res_head),
    .halted    (halted),
    .res_pop   (pop)
  );

  assign empty          = !res_valid;
  assign next_ip        = OUT_W'(res_head.ip);
  assign written_value  = OUT_W'(res_head.written);
  assign reg_zero_value = OUT_W'(res_head.reg0);
  assign bad_index      = res_head.bad;

endmodule

`default_nettype wire

/* verif/six_register_machine_step_core_tb.sv */
`timescale 1ns / 1ps

module six_register_machine_step_core_tb;
  import srm_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASES      = 6;
  localparam int PHASE_ITEMS = 310;

  typedef struct {
    logic [OUT_W-1:0] next_ip;
    logic             halted;
    logic [OUT_W-1:0] written;
    logic [OUT_W-1:0] reg0;
    logic             bad;
  } step_result_t;

  class step_scoreboard;
    logic [DATA_WIDTH-1:0] regs [NUM_REGS];
    logic [DATA_WIDTH-1:0] pointer;
    logic [IPREG_W-1:0]    bound_reg;
    logic [PLEN_W-1:0]     prog_len;
    step_result_t          expected_steps [$];
    int                    errors;

    function new();
      foreach (regs[i]) regs[i] = '0;
      pointer   = '0;
      bound_reg = '0;
      prog_len  = PLEN_RESET;
      errors    = 0;
    endfunction

    function void set_config(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_IP_REGISTER:    bound_reg = val[IPREG_W-1:0];
        CFG_PROGRAM_LENGTH: prog_len  = val[PLEN_W-1:0];
        default: ;
      endcase
    endfunction

    function void decode(input opcode_t op, output kind_t kind,
                         output bit a_reg, output bit b_reg, output bit b_used);
      a_reg  = 1'b1;
      b_reg  = 1'b0;
      b_used = 1'b1;
      case (op)
        OP_ADDR: begin kind = K_ADD; b_reg = 1'b1; end
        OP_ADDI: kind = K_ADD;
        OP_MULR: begin kind = K_MUL; b_reg = 1'b1; end
        OP_MULI: kind = K_MUL;
        OP_BANR: begin kind = K_AND; b_reg = 1'b1; end
        OP_BANI: kind = K_AND;
        OP_BORR: begin kind = K_OR; b_reg = 1'b1; end
        OP_BORI: kind = K_OR;
        OP_SETR: begin kind = K_SET; b_used = 1'b0; end
        OP_SETI: begin kind = K_SET; a_reg = 1'b0; b_used = 1'b0; end
        OP_GTIR: begin kind = K_GT; a_reg = 1'b0; b_reg = 1'b1; end
        OP_GTRI: kind = K_GT;
        OP_GTRR: begin kind = K_GT; b_reg = 1'b1; end
        OP_EQIR: begin kind = K_EQ; a_reg = 1'b0; b_reg = 1'b1; end
        OP_EQRI: kind = K_EQ;
        default: begin kind = K_EQ; b_reg = 1'b1; end
      endcase
    endfunction

    function logic [DATA_WIDTH-1:0] fetch(input logic [OPND_W-1:0] raw, input bit is_reg,
                                          inout bit bad);
      if (!is_reg) return raw;
      if (raw >= NUM_REGS) begin
        bad = 1'b1;
        return '0;
      end
      return regs[raw];
    endfunction

    function void note_instruction(input opcode_t op, input logic [OPND_W-1:0] a_raw,
                                   input logic [OPND_W-1:0] b_raw,
                                   input logic [DEST_W-1:0] dest);
      kind_t                 kind;
      bit                    a_reg, b_reg, b_used, bad, bound;
      logic [DATA_WIDTH-1:0] a, b, res;
      step_result_t          r;
      bad = 1'b0;
      b   = '0;
      decode(op, kind, a_reg, b_reg, b_used);
      bound = (bound_reg < NUM_REGS);
      if (bound) regs[bound_reg] = pointer;
      a = fetch(a_raw, a_reg, bad);
      // operand b of the set forms is never looked at
      if (b_used) b = fetch(b_raw, b_reg, bad);
      if (dest >= NUM_REGS) bad = 1'b1;
      case (kind)
        K_ADD:   res = a + b;
        K_MUL:   res = a * b;
        K_AND:   res = a & b;
        K_OR:    res = a | b;
        K_SET:   res = a;
        K_GT:    res = ($signed(a) > $signed(b)) ? 1 : 0;
        default: res = (a == b) ? 1 : 0;
      endcase
      r.written = '0;
      if (!bad) begin
        regs[dest] = res;
        r.written  = res;
      end
      if (bound) pointer = regs[bound_reg];
      pointer   = pointer + 1;
      r.next_ip = pointer;
      r.halted  = pointer[DATA_WIDTH-1] || (pointer >= prog_len);
      r.reg0    = regs[0];
      r.bad     = bad;
      expected_steps.insert(expected_steps.size(), r);
    endfunction

    function void check_step(input logic [OUT_W-1:0] ip, input logic halt,
                             input logic [OUT_W-1:0] written, input logic [OUT_W-1:0] reg0,
                             input logic bad);
      step_result_t r;
      if (expected_steps.size() == 0) begin
        $error("unexpected result: next_ip %h", ip);
        errors++;
        return;
      end
      r = expected_steps.pop_front();
      if (ip !== r.next_ip) begin
        $error("next_ip expected %h got %h", r.next_ip, ip);
        errors++;
      end
      if (halt !== r.halted) begin
        $error("halted expected %b got %b", r.halted, halt);
        errors++;
      end
      if (written !== r.written) begin
        $error("written_value expected %h got %h", r.written, written);
        errors++;
      end
      if (reg0 !== r.reg0) begin
        $error("reg_zero_value expected %h got %h", r.reg0, reg0);
        errors++;
      end
      if (bad !== r.bad) begin
        $error("bad_index expected %b got %b", r.bad, bad);
        errors++;
      end
    endfunction
  endclass

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    push = 1'b0;
  logic                    full;
  logic [FUNC_W-1:0]       func = '0;
  logic [OPND_W-1:0]       operand_a = '0;
  logic [OPND_W-1:0]       operand_b = '0;
  logic [DEST_W-1:0]       dest_index = '0;
  logic                    empty;
  logic                    pop = 1'b0;
  logic [OUT_W-1:0]        next_ip;
  logic                    halted;
  logic [OUT_W-1:0]        written_value;
  logic [OUT_W-1:0]        reg_zero_value;
  logic                    bad_index;
  logic                    cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_index = CFG_IP_REGISTER;
  logic [CFG_DATA_W-1:0]   cfg_data = '0;

  step_scoreboard sb;
  int             sender_idle = 0;
  int             receiver_idle = 0;
  int             cycle_count = 0;
  logic [IPREG_W-1:0] phase_reg [PHASES] = '{3'd0, 3'd5, 3'd6, 3'd3, 3'd7, 3'd1};
  logic [PLEN_W-1:0]  phase_len [PHASES] = '{11'd0, 11'd2047, 11'd1024, 11'd16, 11'd300,
                                             11'd1024};

  six_register_machine_step_core u_top (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .full           (full),
    .func           (func),
    .operand_a      (operand_a),
    .operand_b      (operand_b),
    .dest_index     (dest_index),
    .empty          (empty),
    .pop            (pop),
    .next_ip        (next_ip),
    .halted         (halted),
    .written_value  (written_value),
    .reg_zero_value (reg_zero_value),
    .bad_index      (bad_index),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        sb.check_step(next_ip, halted, written_value, reg_zero_value, bad_index);
      end
      pop <= ($urandom_range(99) >= receiver_idle);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("** six_register_machine_step_core: FAILED **");
      $finish;
    end
  end

  function automatic logic [OPND_W-1:0] imm_word();
    case ($urandom_range(9))
      0:       return 32'h0000_0000;
      1:       return 32'h0000_0001;
      2:       return 32'hffff_ffff;
      3:       return 32'h7fff_ffff;
      4:       return 32'h8000_0000;
      5, 6:    return $urandom_range(15);
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [OPND_W-1:0] reg_operand(input bit noisy);
    if (noisy && $urandom_range(1) == 0) begin
      case ($urandom_range(3))
        0:       return $urandom_range(NUM_REGS, 7);
        1:       return 32'hffff_ffff;
        2:       return 32'h8000_0000;
        default: return $urandom();
      endcase
    end
    return $urandom_range(NUM_REGS - 1);
  endfunction

  task automatic send_item(input opcode_t op, input logic [OPND_W-1:0] a,
                           input logic [OPND_W-1:0] b, input logic [DEST_W-1:0] dest);
    while ($urandom_range(99) < sender_idle) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push       <= 1'b1;
    func       <= op;
    operand_a  <= a;
    operand_b  <= b;
    dest_index <= dest;
    do @(posedge clk); while (full);
    sb.note_instruction(op, a, b, dest);
  endtask

  task automatic send_random();
    opcode_t           op;
    kind_t             kind;
    bit                a_reg, b_reg, b_used, noisy;
    logic [DEST_W-1:0] dest;
    logic [OPND_W-1:0] a, b;
    op    = opcode_t'($urandom_range(15));
    noisy = ($urandom_range(99) < 15);
    sb.decode(op, kind, a_reg, b_reg, b_used);
    a = a_reg ? reg_operand(noisy) : imm_word();
    b = b_reg ? reg_operand(noisy) : imm_word();
    if (noisy && $urandom_range(2) == 0) begin
      dest = $urandom_range(NUM_REGS, 7);
    end else if (sb.bound_reg < NUM_REGS && $urandom_range(3) == 0) begin
      // write the pointer register so jumps happen
      dest = sb.bound_reg;
    end else begin
      dest = $urandom_range(NUM_REGS - 1);
    end
    send_item(op, a, b, dest);
  endtask

  task automatic wait_drain();
    push <= 1'b0;
    while (sb.expected_steps.size() != 0) @(posedge clk);
  endtask

  task automatic configure(input logic [IPREG_W-1:0] ip_reg, input logic [PLEN_W-1:0] len);
    logic [CFG_DATA_W-1:0] word;
    // upper bits of the pointer-register write are don't-care
    word = $urandom();
    word[IPREG_W-1:0] = ip_reg;
    cfg_we    <= 1'b1;
    cfg_index <= CFG_IP_REGISTER;
    cfg_data  <= word;
    @(posedge clk);
    cfg_index <= CFG_PROGRAM_LENGTH;
    cfg_data  <= len;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_config(CFG_IP_REGISTER, word);
    sb.set_config(CFG_PROGRAM_LENGTH, len);
  endtask

  initial begin
    int p;
    int n;
    sb = new();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    sender_idle   = 25;
    receiver_idle = 68;
    configure(3'd2, PLEN_RESET);

    send_item(OP_SETI, 32'h7fff_ffff, 32'h8000_0000, 3'd0);
    send_item(OP_SETI, 32'h8000_0000, 32'h7fff_ffff, 3'd1);
    send_item(OP_ADDR, 32'd0, 32'd0, 3'd3);
    send_item(OP_ADDI, 32'd1, 32'h8000_0000, 3'd4);
    send_item(OP_MULR, 32'd0, 32'd0, 3'd5);
    send_item(OP_MULI, 32'd1, 32'hffff_ffff, 3'd3);
    send_item(OP_BANR, 32'd0, 32'd1, 3'd4);
    send_item(OP_BANI, 32'd0, 32'h0000_ffff, 3'd4);
    send_item(OP_BORR, 32'd0, 32'd1, 3'd5);
    send_item(OP_BORI, 32'd1, 32'h5a5a_5a5a, 3'd5);
    // unused operand b of setr is out of range but must not flag
    send_item(OP_SETR, 32'd0, 32'hffff_ffff, 3'd3);
    send_item(OP_GTRR, 32'd0, 32'd1, 3'd4);
    send_item(OP_GTIR, 32'h8000_0000, 32'd0, 3'd4);
    send_item(OP_GTRI, 32'd1, 32'hffff_ffff, 3'd4);
    send_item(OP_EQRR, 32'd0, 32'd0, 3'd5);
    send_item(OP_EQRI, 32'd0, 32'h7fff_ffff, 3'd5);
    send_item(OP_EQIR, 32'h7fff_ffff, 32'd0, 3'd5);
    // out-of-range register operands and destinations
    send_item(OP_ADDR, 32'd6, 32'd0, 3'd3);
    send_item(OP_ADDR, 32'd0, 32'hffff_ffff, 3'd3);
    send_item(OP_SETI, 32'd5, 32'd0, 3'd6);
    send_item(OP_SETR, 32'hffff_ffff, 32'd0, 3'd7);
    // jumps through the pointer register, wrap negative, halt boundary
    send_item(OP_SETI, 32'd999, 32'd0, 3'd2);
    send_item(OP_SETI, 32'h7fff_fffe, 32'd0, 3'd2);
    send_item(OP_ADDI, 32'd0, 32'd1, 3'd0);
    send_item(OP_SETI, 32'd1022, 32'd0, 3'd2);
    send_item(OP_EQIR, 32'd0, 32'd2, 3'd1);

    for (p = 0; p < PHASES; p++) begin
      wait_drain();
      configure(phase_reg[p], phase_len[p]);
      if (p < 2) begin
        sender_idle   = 25;
        receiver_idle = 68;
      end else if (p < 4) begin
        sender_idle   = 68;
        receiver_idle = 25;
      end else begin
        sender_idle   = 0;
        receiver_idle = 0;
      end
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 3 && n == PHASE_ITEMS / 2) wait_drain();
        send_random();
      end
    end

    wait_drain();
    repeat (8) @(posedge clk);
    if (sb.errors == 0) begin
      $display("** six_register_machine_step_core: PASSED **");
    end else begin
      $display("** six_register_machine_step_core: FAILED **");
    end
    $finish;
  end

endmodule

/* sim.f */
design/srm_pkg.sv
design/srm_ram.sv
design/srm_front.sv
design/srm_back.sv
design/six_register_machine_step_core.sv
verif/six_register_machine_step_core_tb.sv
